FILE: rtl/ssca_pkg.sv
// ----------------------------------------------------------------------------
// ssca_pkg
// Shared types and constants of the segregated size-class allocator.
// ----------------------------------------------------------------------------
package ssca_pkg;

   localparam int DEF_REGION_PAGES = 16;
   localparam int DEF_CLASS_COUNT  = 8;
   localparam int PAGE_BYTES       = 4096;
   localparam int LINK_BYTES       = 8;

   typedef enum logic [1:0] {
      CMD_ALLOC  = 2'd0,
      CMD_FREE   = 2'd1,
      CMD_RESIZE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      RS_OK      = 3'd0,
      RS_ZERO    = 3'd1,
      RS_LARGE   = 3'd2,
      RS_NOPAGE  = 3'd3,
      RS_BADFREE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CARVE_START,
      OP_CARVE_STEP,
      OP_POP_DONE,
      OP_PUSH
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_CARVE,
      ST_POP_RD,
      ST_POP_DONE,
      ST_PUSH,
      ST_FINISH
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic       load_req;
      op_type     op;
      logic       use_old;
      logic       res_status_we;
      status_type res_status;
      logic       res_keep;
      logic       res_copy;
      logic       publish;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      cmd_type command;
      logic    size_zero;
      logic    size_large;
      logic    addr_zero;
      logic    head_empty;
      logic    no_page;
      logic    bad_block;
      logic    grow;
      logic    carve_more;
   } dp_status_type;

endpackage

FILE: rtl/ssca_if.sv
// ----------------------------------------------------------------------------
// ssca_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface ssca_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [15:0] request_size;
   logic [15:0] block_address;

   modport source (output valid, command, request_size, block_address, input ready);
   modport sink   (input valid, command, request_size, block_address, output ready);
endinterface

interface ssca_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] address;
   logic [10:0] copy_bytes;
   logic [2:0]  status;

   modport source (output valid, address, copy_bytes, status, input ready);
   modport sink   (input valid, address, copy_bytes, status, output ready);
endinterface

FILE: rtl/segregated_size_class_allocator_core.sv
// ----------------------------------------------------------------------------
// segregated_size_class_allocator_core
// Size-class allocator over 4096-byte pages with per-class LIFO free lists.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Payload                                    Handshake
//   req       in    command, request_size, block_address       valid/ready
//   rsp       out   address, copy_bytes, status                valid/ready
//   csr       in    csr_wdata (page_limit, 5 bits)             csr_we strobe
//
// One item is taken at a time, and only in idle. An allocate from a non-empty
// list passes through decide, link read, pop and finish; a free through
// decide, push and finish; a growing resize through decide, link read, pop,
// push and finish. An allocate that carves a fresh page first writes one link
// per block through the single write port of the link memory and then closes
// the carve before the pop. Reset is synchronous and clears the list heads,
// page table and carved count and sets the page limit to 16; the link memory
// is not cleared. The response register lets a new item enter while the last
// result waits; the next item then holds in finish until it is taken.
// ----------------------------------------------------------------------------
module segregated_size_class_allocator_core #(
   parameter int REGION_PAGES = ssca_pkg::DEF_REGION_PAGES,
   parameter int CLASS_COUNT  = ssca_pkg::DEF_CLASS_COUNT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_we,
   input  logic [4:0] csr_wdata,
   ssca_req_if.sink  req,
   ssca_rsp_if.source rsp
);
   import ssca_pkg::*;

   // Commands from the sequencer and the flags it branches on.
   dp_cmd_type    cmd;
   dp_status_type stat;

   ssca_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the lists, the page table and the result registers.
   ssca_datapath #(
      .REGION_PAGES (REGION_PAGES),
      .CLASS_COUNT  (CLASS_COUNT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_command       (req.command),
      .req_request_size  (req.request_size),
      .req_block_address (req.block_address),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_address       (rsp.address),
      .rsp_copy_bytes    (rsp.copy_bytes),
      .rsp_status        (rsp.status)
   );
endmodule

FILE: rtl/ssca_ram.sv
// ----------------------------------------------------------------------------
// ssca_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssca_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/ssca_datapath.sv
// ----------------------------------------------------------------------------
// ssca_datapath
// List heads, page table, link memory, carving counter and result registers.
// ----------------------------------------------------------------------------
module ssca_datapath #(
   parameter int REGION_PAGES = 16,
   parameter int CLASS_COUNT  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [4:0]             csr_wdata,
   input  logic [1:0]             req_command,
   input  logic [15:0]            req_request_size,
   input  logic [15:0]            req_block_address,
   input  ssca_pkg::dp_cmd_type   cmd,
   output ssca_pkg::dp_status_type stat,
   output logic [15:0]            rsp_address,
   output logic [10:0]            rsp_copy_bytes,
   output logic [2:0]             rsp_status
);
   import ssca_pkg::*;

   localparam int USABLE_PAGES = (REGION_PAGES < 16) ? REGION_PAGES : 16;
   localparam int LINK_DEPTH   = USABLE_PAGES * (PAGE_BYTES / LINK_BYTES);
   localparam int LINK_AW      = $clog2(LINK_DEPTH);
   localparam int CLS_W        = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam logic [16:0] LARGEST = 17'(8 << (CLASS_COUNT - 1));

   function automatic logic [15:0][3:0] page_mod_table();
      logic [15:0][3:0] t;
      for (int i = 0; i < 16; i++) begin
         t[i] = 4'(i % USABLE_PAGES);
      end
      return t;
   endfunction

   localparam logic [15:0][3:0] PAGE_MOD = page_mod_table();

   function automatic logic [LINK_AW-1:0] link_index(input logic [15:0] off);
      logic [12:0] v;
      logic [12:0] full;
      v    = off[15:3];
      full = {PAGE_MOD[v[12:9]], v[8:0]};
      return full[LINK_AW-1:0];
   endfunction

   logic [1:0]  cmd_ff;
   logic [15:0] size_ff;
   logic [15:0] addr_ff;
   logic [4:0]  page_limit_ff;
   logic [4:0]  pages_carved_ff;
   logic [15:0] class_head_ff [CLASS_COUNT];
   logic [3:0]  page_class_ff [16];
   logic [3:0]  carve_page_ff;
   logic [12:0] carve_off_ff;
   logic [12:0] stride_ff;
   logic [CLS_W-1:0] carve_cls_ff;
   logic [15:0] res_addr_ff;
   logic [10:0] res_copy_ff;
   status_type  res_status_ff;
   logic [15:0] rsp_address_ff;
   logic [10:0] rsp_copy_ff;
   logic [2:0]  rsp_status_ff;

   logic [CLS_W-1:0] cls_alloc;
   logic [CLS_W-1:0] cls_old;
   logic [CLS_W-1:0] hd_idx;
   logic [15:0]      head_rd;
   logic [3:0]       pc;
   logic [11:0]      blk_bytes;
   logic [4:0]       lim;
   logic [15:0]      carve_lk;
   logic [15:0]      push_lk;
   logic             ram_we;
   logic [LINK_AW-1:0] ram_waddr;
   logic [15:0]      ram_wdata;
   logic [15:0]      ram_rdata;

   // Smallest class that holds the request.
   always_comb begin
      cls_alloc = CLS_W'(CLASS_COUNT - 1);
      for (int c = CLASS_COUNT - 2; c >= 0; c--) begin
         if ({1'b0, size_ff} <= (17'd8 << c)) begin
            cls_alloc = CLS_W'(c);
         end
      end
   end

   assign pc        = (addr_ff[11:0] < 12'd16) ? 4'd0 : page_class_ff[addr_ff[15:12]];
   assign cls_old   = CLS_W'(pc - 4'd1);
   assign blk_bytes = 12'd8 << (pc - 4'd1);
   assign hd_idx    = cmd.use_old ? cls_old : cls_alloc;
   assign head_rd   = class_head_ff[hd_idx];
   assign lim       = (page_limit_ff > 5'(USABLE_PAGES)) ? 5'(USABLE_PAGES) : page_limit_ff;
   assign carve_lk  = {carve_page_ff, carve_off_ff[11:0]};
   assign push_lk   = addr_ff - 16'd8;

   always_comb begin
      stat.command    = cmd_type'(cmd_ff);
      stat.size_zero  = (size_ff == 16'd0);
      stat.size_large = ({1'b0, size_ff} > LARGEST);
      stat.addr_zero  = (addr_ff == 16'd0);
      stat.head_empty = (head_rd == 16'd0);
      stat.no_page    = (pages_carved_ff >= lim);
      stat.bad_block  = (pc == 4'd0) || ({28'd0, pc} > CLASS_COUNT);
      stat.grow       = (size_ff > {4'd0, blk_bytes});
      stat.carve_more = ((carve_off_ff + stride_ff) <= 13'(PAGE_BYTES));
   end

   assign ram_we    = (cmd.op == OP_CARVE_STEP) || (cmd.op == OP_PUSH);
   assign ram_waddr = (cmd.op == OP_PUSH) ? link_index(push_lk) : link_index(carve_lk);
   assign ram_wdata = (cmd.op == OP_PUSH) ? head_rd : class_head_ff[carve_cls_ff];

   ssca_ram #(.WIDTH(16), .DEPTH(LINK_DEPTH)) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (link_index(head_rd)),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         page_limit_ff   <= 5'd16;
         pages_carved_ff <= 5'd0;
         for (int i = 0; i < CLASS_COUNT; i++) begin
            class_head_ff[i] <= 16'd0;
         end
         for (int i = 0; i < 16; i++) begin
            page_class_ff[i] <= 4'd0;
         end
      end else begin
         if (csr_we) begin
            page_limit_ff <= csr_wdata;
         end
         unique case (cmd.op)
            OP_CARVE_START: begin
               page_class_ff[pages_carved_ff[3:0]] <= 4'(cls_alloc) + 4'd1;
               pages_carved_ff <= pages_carved_ff + 5'd1;
            end
            OP_CARVE_STEP: begin
               class_head_ff[carve_cls_ff] <= carve_lk;
            end
            OP_POP_DONE: begin
               class_head_ff[hd_idx] <= ram_rdata;
            end
            OP_PUSH: begin
               class_head_ff[hd_idx] <= push_lk;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff        <= req_command;
         size_ff       <= req_request_size;
         addr_ff       <= req_block_address;
         res_addr_ff   <= 16'd0;
         res_copy_ff   <= 11'd0;
         res_status_ff <= RS_OK;
      end
      if (cmd.op == OP_CARVE_START) begin
         carve_page_ff <= pages_carved_ff[3:0];
         carve_off_ff  <= 13'd8;
         stride_ff     <= (13'd8 << cls_alloc) + 13'd8;
         carve_cls_ff  <= cls_alloc;
      end
      if (cmd.op == OP_CARVE_STEP) begin
         carve_off_ff <= carve_off_ff + stride_ff;
      end
      if (cmd.op == OP_POP_DONE) begin
         res_addr_ff <= head_rd + 16'd8;
      end
      if (cmd.res_status_we) begin
         res_status_ff <= cmd.res_status;
      end
      if (cmd.res_keep) begin
         res_addr_ff <= addr_ff;
      end
      if (cmd.res_copy) begin
         res_copy_ff <= blk_bytes[10:0];
      end
      if (cmd.publish) begin
         rsp_address_ff <= res_addr_ff;
         rsp_copy_ff    <= res_copy_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   assign rsp_address    = rsp_address_ff;
   assign rsp_copy_bytes = rsp_copy_ff;
   assign rsp_status     = rsp_status_ff;
endmodule

FILE: rtl/ssca_ctrl.sv
// ----------------------------------------------------------------------------
// ssca_ctrl
// Sequencer that steps the datapath through allocate, carve, pop and push.
// ----------------------------------------------------------------------------
module ssca_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  ssca_pkg::dp_status_type stat,
   output ssca_pkg::dp_cmd_type    cmd
);
   import ssca_pkg::*;

   state_type state_ff, state_in;
   logic      grow_ff, grow_in;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         grow_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         grow_ff  <= grow_in;
         if (cmd.publish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      logic do_alloc;
      logic do_free;
      state_in = state_ff;
      grow_in  = grow_ff;
      cmd      = '0;
      cmd.op   = OP_NONE;
      cmd.res_status = RS_OK;
      do_alloc = 1'b0;
      do_free  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load_req = req_valid;
            grow_in      = 1'b0;
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            unique case (stat.command)
               CMD_ALLOC: do_alloc = 1'b1;
               CMD_FREE:  do_free  = 1'b1;
               CMD_RESIZE: begin
                  priority if (stat.addr_zero) begin
                     do_alloc = 1'b1;
                  end else if (stat.size_zero) begin
                     do_free = 1'b1;
                  end else if (stat.bad_block) begin
                     cmd.res_status_we = 1'b1;
                     cmd.res_status    = RS_BADFREE;
                     state_in          = ST_FINISH;
                  end else if (stat.grow) begin
                     grow_in  = 1'b1;
                     do_alloc = 1'b1;
                  end else begin
                     cmd.res_keep = 1'b1;
                     state_in     = ST_FINISH;
                  end
               end
               default: state_in = ST_FINISH;
            endcase
            if (do_alloc) begin
               priority if (stat.size_zero) begin
                  cmd.res_status_we = 1'b1;
                  cmd.res_status    = RS_ZERO;
                  state_in          = ST_FINISH;
               end else if (stat.size_large) begin
                  cmd.res_status_we = 1'b1;
                  cmd.res_status    = RS_LARGE;
                  state_in          = ST_FINISH;
               end else if (stat.head_empty && stat.no_page) begin
                  cmd.res_status_we = 1'b1;
                  cmd.res_status    = RS_NOPAGE;
                  state_in          = ST_FINISH;
               end else if (stat.head_empty) begin
                  cmd.op   = OP_CARVE_START;
                  state_in = ST_CARVE;
               end else begin
                  state_in = ST_POP_RD;
               end
            end
            if (do_free) begin
               priority if (stat.addr_zero) begin
                  state_in = ST_FINISH;
               end else if (stat.bad_block) begin
                  cmd.res_status_we = 1'b1;
                  cmd.res_status    = RS_BADFREE;
                  state_in          = ST_FINISH;
               end else begin
                  state_in = ST_PUSH;
               end
            end
         end
         ST_CARVE: begin
            if (stat.carve_more) begin
               cmd.op = OP_CARVE_STEP;
            end else begin
               state_in = ST_POP_RD;
            end
         end
         ST_POP_RD: begin
            state_in = ST_POP_DONE;
         end
         ST_POP_DONE: begin
            cmd.op   = OP_POP_DONE;
            state_in = grow_ff ? ST_PUSH : ST_FINISH;
         end
         ST_PUSH: begin
            cmd.op       = OP_PUSH;
            cmd.use_old  = 1'b1;
            cmd.res_copy = grow_ff;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule
